// ===== rtl/core/bse_pkg.sv =====
// shared types, codes and helpers for the bezier surface evaluator
package bse_pkg;

    localparam int ACC_W     = 64;
    localparam int OUT_BITS  = 40;
    localparam int NUM_OUT   = 9;
    localparam int OUT_TW    = OUT_BITS * NUM_OUT;
    localparam int STEP_W    = 4;
    localparam int ACC_IDX_W = 4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    localparam logic [1:0] REG_DEGREE_U = 2'd0;
    localparam logic [1:0] REG_DEGREE_V = 2'd1;

    // per point: three weight products, then nine coordinate macs
    localparam logic [STEP_W-1:0] STEP_W0    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_W1    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_W2    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MAC0  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd11;

    localparam logic [ACC_IDX_W-1:0] LAST_OUT = 4'd8;

    // writeback tag, registered alongside the shared multiplier's product
    typedef struct packed {
        logic                 valid;
        logic                 is_mac;
        logic [ACC_IDX_W-1:0] idx;
    } wb_tag_t;

    function automatic logic [1:0] binom_coef(input logic [1:0] n, input logic [1:0] i);
        logic [1:0] c;
        c = 2'd0;
        if (i <= n) begin
            if (n == 2'd3 && (i == 2'd1 || i == 2'd2))
                c = 2'd3;
            else if (n == 2'd2 && i == 2'd1)
                c = 2'd2;
            else
                c = 2'd1;
        end
        return c;
    endfunction

    // coordinate component (x, y, z) used by a mac step
    function automatic logic [1:0] mac_comp(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] k;
        logic [1:0]        r;
        k = step - STEP_MAC0;
        priority if (k < 4'd3)
            r = k[1:0];
        else if (k < 4'd6)
            r = 2'(k - 4'd3);
        else
            r = 2'(k - 4'd6);
        return r;
    endfunction

    // weight (value, d/du, d/dv) used by a mac step
    function automatic logic [1:0] mac_wsel(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] k;
        logic [1:0]        r;
        k = step - STEP_MAC0;
        priority if (k < 4'd3)
            r = 2'd0;
        else if (k < 4'd6)
            r = 2'd1;
        else
            r = 2'd2;
        return r;
    endfunction

endpackage

// ===== rtl/core/bezier_surface_eval.sv =====
// bezier patch evaluator: control point grid, basis sequencer and shared multiplier
// a load beat writes one grid point and leaves the sequencer idle; an evaluate beat runs
// the basis pass, then the point pass over the (du+1)(dv+1) control points, then a drain
// step and the finish pass; the basis and point passes share the one multiplier, while the
// finish pass rounds and saturates the accumulators without it
// one beat at a time: s_tready is low from an evaluate beat until its result beat is taken
// rst_n clears the grid to zero, both degrees to 0 and the sequencer to idle
module bezier_surface_eval #(
    parameter int MAX_DEGREE      = 3,
    parameter int COORD_BITS      = 32,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int PB     = PARAM_FRAC_BITS + 2,
    localparam int IN_RAW = 4 + 3 * COORD_BITS + 2 * PB,
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // point_row, point_col, coord_x, coord_y, coord_z, param_u, param_v
    input  logic [IN_W-1:0]            s_tdata,
    // action
    input  logic [0:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // pos_x, pos_y, pos_z, tan_u_x, tan_u_y, tan_u_z, tan_v_x, tan_v_y, tan_v_z
    output logic [bse_pkg::OUT_TW-1:0] m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [1:0]                 cfg_data
);

    localparam int F      = PARAM_FRAC_BITS;
    localparam int GRID_N = MAX_DEGREE + 1;
    localparam int GRID_D = GRID_N * GRID_N;
    localparam int IW     = (MAX_DEGREE > 1) ? 2 : 1;
    localparam int EW     = $clog2(GRID_D);
    localparam int KW     = IW + 1;
    localparam int TW     = F + 1;
    localparam int BW     = F + 2;
    localparam int DW     = F + 5;
    localparam int WW     = F + 6;
    localparam int MA     = (COORD_BITS > WW) ? COORD_BITS : WW;
    localparam int MB     = WW;
    localparam int PW     = MA + MB;
    localparam int AW     = bse_pkg::ACC_W;
    localparam int OB     = bse_pkg::OUT_BITS;

    localparam logic [TW-1:0]        ONE      = TW'(1) << F;
    localparam logic signed [PW-1:0] HALF_P   = PW'(1) << (F - 1);
    localparam logic signed [AW-1:0] HALF_A   = AW'(1) << (F - 1);
    localparam logic signed [AW-1:0] OUT_HI   = (AW'(1) << (OB - 1)) - AW'(1);
    localparam logic signed [AW-1:0] OUT_LO   = -(AW'(1) << (OB - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BCHAIN,
        ST_BWB,
        ST_POINT,
        ST_DRAIN,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [IW-1:0] deg_u_reg;
    logic [IW-1:0] deg_v_reg;

    logic signed [COORD_BITS-1:0] gx_reg [GRID_D];
    logic signed [COORD_BITS-1:0] gy_reg [GRID_D];
    logic signed [COORD_BITS-1:0] gz_reg [GRID_D];

    logic [TW-1:0] u_reg;
    logic [TW-1:0] v_reg;

    // basis pass counters
    logic          ax_reg;
    logic          lvl_reg;
    logic [IW-1:0] bi_reg;
    logic [KW-1:0] bk_reg;
    logic [TW-1:0] p_reg;
    logic [BW-1:0] prev_reg;

    logic [BW-1:0]        bn_u_reg [GRID_N];
    logic [BW-1:0]        bn_v_reg [GRID_N];
    logic signed [DW-1:0] dr_u_reg [GRID_N];
    logic signed [DW-1:0] dr_v_reg [GRID_N];

    // point pass
    logic [IW-1:0]                 pi_reg;
    logic [IW-1:0]                 pj_reg;
    logic [bse_pkg::STEP_W-1:0]    step_reg;
    logic signed [WW-1:0]          w_reg [3];
    logic signed [AW-1:0]          acc_reg [bse_pkg::NUM_OUT];
    logic [bse_pkg::ACC_IDX_W-1:0] fidx_reg;
    logic signed [OB-1:0]          out_reg [bse_pkg::NUM_OUT];

    logic signed [PW-1:0] prod_reg;
    bse_pkg::wb_tag_t     wb_reg;

    // input fields
    logic [1:0]                   in_row;
    logic [1:0]                   in_col;
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic signed [COORD_BITS-1:0] in_z;
    logic signed [PB-1:0]         in_u;
    logic signed [PB-1:0]         in_v;
    logic                         in_fire;
    logic [EW-1:0]                load_idx;

    assign in_row = s_tdata[1:0];
    assign in_col = s_tdata[3:2];
    assign in_x   = s_tdata[4 +: COORD_BITS];
    assign in_y   = s_tdata[4 + COORD_BITS +: COORD_BITS];
    assign in_z   = s_tdata[4 + 2 * COORD_BITS +: COORD_BITS];
    assign in_u   = s_tdata[4 + 3 * COORD_BITS +: PB];
    assign in_v   = s_tdata[4 + 3 * COORD_BITS + PB +: PB];

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign load_idx  = EW'(int'(in_row) * GRID_N + int'(in_col));

    for (genvar g = 0; g < bse_pkg::NUM_OUT; g++) begin : g_out
        assign m_tdata[g * OB +: OB] = out_reg[g];
    end

    function automatic logic [TW-1:0] clamp_param(input logic signed [PB-1:0] raw);
        logic [TW-1:0] r;
        priority if (raw[PB-1])
            r = '0;
        else if (raw > $signed({1'b0, ONE}))
            r = ONE;
        else
            r = TW'(raw);
        return r;
    endfunction

    function automatic logic [IW-1:0] clamp_deg(input logic [1:0] d);
        logic [IW-1:0] r;
        if (int'(d) > MAX_DEGREE)
            r = IW'(MAX_DEGREE);
        else
            r = IW'(d);
        return r;
    endfunction

    // basis pass datapath
    logic [IW-1:0]        n_cur;
    logic [IW-1:0]        m_cur;
    logic [TW-1:0]        t_cur;
    logic [TW-1:0]        f_sel;
    logic                 chain_done;
    logic [BW-1:0]        bval;
    logic signed [DW-1:0] d_lo;
    logic signed [DW-1:0] d_hi;
    logic signed [DW-1:0] dif;

    always_comb
    begin
        n_cur      = ax_reg ? deg_v_reg : deg_u_reg;
        m_cur      = lvl_reg ? IW'(n_cur - IW'(1)) : n_cur;
        t_cur      = ax_reg ? v_reg : u_reg;
        f_sel      = (bk_reg <= KW'(bi_reg)) ? t_cur : TW'(ONE - t_cur);
        chain_done = (bk_reg > KW'(m_cur));
        bval       = BW'(p_reg) * BW'(bse_pkg::binom_coef(2'(m_cur), 2'(bi_reg)));
        dif        = DW'($signed({1'b0, prev_reg})) - DW'($signed({1'b0, bval}));
        d_lo       = DW'(dif * $signed({1'b0, n_cur}));
        d_hi       = DW'($signed({1'b0, bval}) * $signed({1'b0, n_cur}));
    end

    // shared multiplier operand select
    logic [EW-1:0]                pt_idx;
    logic [1:0]                   comp;
    logic [1:0]                   wsel;
    logic signed [COORD_BITS-1:0] coord_sel;
    logic signed [MA-1:0]         op_a;
    logic signed [MB-1:0]         op_b;
    logic signed [PW-1:0]         rnd;

    always_comb
    begin
        pt_idx = EW'(int'(pi_reg) * GRID_N + int'(pj_reg));
        comp   = bse_pkg::mac_comp(step_reg);
        wsel   = bse_pkg::mac_wsel(step_reg);
        unique case (comp)
            2'd0:    coord_sel = gx_reg[pt_idx];
            2'd1:    coord_sel = gy_reg[pt_idx];
            default: coord_sel = gz_reg[pt_idx];
        endcase
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_BCHAIN:
            begin
                op_a = MA'($signed({1'b0, p_reg}));
                op_b = MB'($signed({1'b0, f_sel}));
            end
            ST_POINT:
            begin
                priority if (step_reg == bse_pkg::STEP_W0)
                begin
                    op_a = MA'($signed({1'b0, bn_u_reg[pi_reg]}));
                    op_b = MB'($signed({1'b0, bn_v_reg[pj_reg]}));
                end
                else if (step_reg == bse_pkg::STEP_W1)
                begin
                    op_a = MA'(dr_u_reg[pi_reg]);
                    op_b = MB'($signed({1'b0, bn_v_reg[pj_reg]}));
                end
                else if (step_reg == bse_pkg::STEP_W2)
                begin
                    op_a = MA'(dr_v_reg[pj_reg]);
                    op_b = MB'($signed({1'b0, bn_u_reg[pi_reg]}));
                end
                else
                begin
                    op_a = MA'(coord_sel);
                    op_b = w_reg[wsel];
                end
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        rnd = (prod_reg + HALF_P) >>> F;
    end

    // finish: round and saturate one accumulator per cycle
    logic signed [AW-1:0] fin_r;
    logic signed [AW-1:0] fin_v;
    logic signed [OB-1:0] fin_sat;

    always_comb
    begin
        fin_r = acc_reg[fidx_reg] + HALF_A;
        fin_v = fin_r >>> F;
        priority if (fin_v > OUT_HI)
            fin_sat = OB'(OUT_HI);
        else if (fin_v < OUT_LO)
            fin_sat = OB'(OUT_LO);
        else
            fin_sat = OB'(fin_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            deg_u_reg <= '0;
            deg_v_reg <= '0;
            for (int k = 0; k < GRID_D; k++)
            begin
                gx_reg[k] <= '0;
                gy_reg[k] <= '0;
                gz_reg[k] <= '0;
            end
            ax_reg   <= 1'b0;
            lvl_reg  <= 1'b0;
            bi_reg   <= '0;
            bk_reg   <= '0;
            pi_reg   <= '0;
            pj_reg   <= '0;
            step_reg <= '0;
            fidx_reg <= '0;
            wb_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bse_pkg::REG_DEGREE_U: deg_u_reg <= clamp_deg(cfg_data);
                    bse_pkg::REG_DEGREE_V: deg_v_reg <= clamp_deg(cfg_data);
                    default: ;
                endcase
            end

            prod_reg <= op_a * op_b;

            // writeback of the previous point-pass product
            if (wb_reg.valid)
            begin
                if (wb_reg.is_mac)
                    acc_reg[wb_reg.idx] <= acc_reg[wb_reg.idx] + AW'(prod_reg);
                else
                    w_reg[wb_reg.idx[1:0]] <= WW'(rnd);
            end
            wb_reg.valid  <= (state_reg == ST_POINT);
            wb_reg.is_mac <= (step_reg >= bse_pkg::STEP_MAC0);
            wb_reg.idx    <= (step_reg >= bse_pkg::STEP_MAC0) ?
                             bse_pkg::ACC_IDX_W'(step_reg - bse_pkg::STEP_MAC0) :
                             bse_pkg::ACC_IDX_W'(step_reg);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_tuser[0] == bse_pkg::ACT_LOAD)
                        begin
                            if (int'(in_row) <= MAX_DEGREE && int'(in_col) <= MAX_DEGREE)
                            begin
                                gx_reg[load_idx] <= in_x;
                                gy_reg[load_idx] <= in_y;
                                gz_reg[load_idx] <= in_z;
                            end
                        end
                        else
                        begin
                            u_reg    <= clamp_param(in_u);
                            v_reg    <= clamp_param(in_v);
                            for (int k = 0; k < bse_pkg::NUM_OUT; k++)
                                acc_reg[k] <= '0;
                            for (int k = 0; k < GRID_N; k++)
                            begin
                                dr_u_reg[k] <= '0;
                                dr_v_reg[k] <= '0;
                            end
                            ax_reg   <= 1'b0;
                            lvl_reg  <= 1'b0;
                            bi_reg   <= '0;
                            bk_reg   <= KW'(1);
                            p_reg    <= ONE;
                            prev_reg <= '0;
                            state_reg <= ST_BCHAIN;
                        end
                    end
                end
                ST_BCHAIN:
                begin
                    if (chain_done)
                    begin
                        if (!lvl_reg)
                        begin
                            if (ax_reg)
                                bn_v_reg[bi_reg] <= bval;
                            else
                                bn_u_reg[bi_reg] <= bval;
                        end
                        else
                        begin
                            // derivative from the degree n-1 basis, neighbors pairwise
                            if (ax_reg)
                            begin
                                dr_v_reg[bi_reg] <= d_lo;
                                if (bi_reg == m_cur)
                                    dr_v_reg[IW'(bi_reg + IW'(1))] <= d_hi;
                            end
                            else
                            begin
                                dr_u_reg[bi_reg] <= d_lo;
                                if (bi_reg == m_cur)
                                    dr_u_reg[IW'(bi_reg + IW'(1))] <= d_hi;
                            end
                        end
                        p_reg  <= ONE;
                        bk_reg <= KW'(1);
                        if (bi_reg != m_cur)
                        begin
                            bi_reg   <= bi_reg + IW'(1);
                            prev_reg <= bval;
                        end
                        else
                        begin
                            bi_reg   <= '0;
                            prev_reg <= '0;
                            priority if (!lvl_reg && n_cur != '0)
                                lvl_reg <= 1'b1;
                            else if (!ax_reg)
                            begin
                                ax_reg  <= 1'b1;
                                lvl_reg <= 1'b0;
                            end
                            else
                            begin
                                pi_reg    <= '0;
                                pj_reg    <= '0;
                                step_reg  <= bse_pkg::STEP_W0;
                                state_reg <= ST_POINT;
                            end
                        end
                    end
                    else
                        state_reg <= ST_BWB;
                end
                ST_BWB:
                begin
                    p_reg     <= TW'(rnd);
                    bk_reg    <= bk_reg + KW'(1);
                    state_reg <= ST_BCHAIN;
                end
                ST_POINT:
                begin
                    if (step_reg == bse_pkg::STEP_LAST)
                    begin
                        step_reg <= bse_pkg::STEP_W0;
                        if (pj_reg == deg_v_reg)
                        begin
                            pj_reg <= '0;
                            if (pi_reg == deg_u_reg)
                                state_reg <= ST_DRAIN;
                            else
                                pi_reg <= pi_reg + IW'(1);
                        end
                        else
                            pj_reg <= pj_reg + IW'(1);
                    end
                    else
                        step_reg <= step_reg + bse_pkg::STEP_W'(1);
                end
                ST_DRAIN:
                begin
                    fidx_reg  <= '0;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    out_reg[fidx_reg] <= fin_sat;
                    if (fidx_reg == bse_pkg::LAST_OUT)
                        state_reg <= ST_OUT;
                    else
                        fidx_reg <= fidx_reg + bse_pkg::ACC_IDX_W'(1);
                end
                ST_OUT:
                begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_eval_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser[0] == bse_pkg::ACT_EVAL) |=> !m_tvalid)
        else $error("result beat right after evaluate beat");

    a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser[0] == bse_pkg::ACT_LOAD) |=> s_tready)
        else $error("load beat left the sequencer busy");

    a_wb_only_in_points: assert property (@(posedge clk) disable iff (!rst_n)
        wb_reg.valid |-> (state_reg == ST_POINT || state_reg == ST_DRAIN))
        else $error("multiplier writeback outside point pass");

    a_point_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POINT) |-> (pi_reg <= deg_u_reg && pj_reg <= deg_v_reg
                                     && step_reg <= bse_pkg::STEP_LAST))
        else $error("point pass index out of range");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("result beat without finish pass");

endmodule

// ===== dv/bezier_surface_eval_tb.sv =====
// self-checking testbench for the bezier patch evaluator: predicted results vs. the block
`timescale 1ns / 100ps

module bezier_surface_eval_tb;

    localparam int IN_W       = 136;
    localparam int ONE        = 65536;
    localparam longint SAT_HI = (64'sd1 <<< 39) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam int CYCLE_CAP  = 2000000;
    localparam logic [1:0] REG_UNUSED_A = 2'd2;
    localparam logic [1:0] REG_UNUSED_B = 2'd3;

    class patch_scoreboard;
        int unsigned                deg_u;
        int unsigned                deg_v;
        longint                     gx[16];
        longint                     gy[16];
        longint                     gz[16];
        logic [bse_pkg::OUT_TW-1:0] surface_q[$];
        int                         errors;

        function new();
            deg_u = 0;
            deg_v = 0;
            errors = 0;
            foreach (gx[k])
            begin
                gx[k] = 0;
                gy[k] = 0;
                gz[k] = 0;
            end
        endfunction

        function void apply_config(logic [1:0] idx, logic [1:0] val);
            if (idx == bse_pkg::REG_DEGREE_U)
                deg_u = val;
            else if (idx == bse_pkg::REG_DEGREE_V)
                deg_v = val;
        endfunction

        function longint bernstein(int n, int i, longint t);
            longint p;
            longint f;
            longint c;
            if (i > n)
                return 0;
            p = ONE;
            for (int k = 1; k <= n; k++)
            begin
                f = (k <= i) ? t : ONE - t;
                p = (p * f + 32768) >>> 16;
            end
            c = (n == 3 && (i == 1 || i == 2)) ? 3 : ((n == 2 && i == 1) ? 2 : 1);
            return c * p;
        endfunction

        function longint bernstein_slope(int n, int i, longint t);
            longint a;
            longint b;
            if (n == 0)
                return 0;
            a = (i > 0) ? bernstein(n - 1, i - 1, t) : 0;
            b = (i < n) ? bernstein(n - 1, i, t) : 0;
            return n * (a - b);
        endfunction

        function longint round_q(longint x);
            return (x + 32768) >>> 16;
        endfunction

        function longint clamp_param(logic signed [17:0] raw);
            longint r;
            r = raw;
            if (r < 0)
                r = 0;
            if (r > ONE)
                r = ONE;
            return r;
        endfunction

        function void note_beat(logic act, logic [1:0] row, logic [1:0] col,
                                logic signed [31:0] x, logic signed [31:0] y,
                                logic signed [31:0] z, logic signed [17:0] pu,
                                logic signed [17:0] pv);
            longint acc[9];
            longint u;
            longint v;
            longint bu;
            longint bv;
            longint dbu;
            longint dbv;
            longint w[3];
            longint pt[3];
            longint r;
            logic [bse_pkg::OUT_TW-1:0] res;
            if (act == bse_pkg::ACT_LOAD)
            begin
                gx[row * 4 + col] = x;
                gy[row * 4 + col] = y;
                gz[row * 4 + col] = z;
                return;
            end
            u = clamp_param(pu);
            v = clamp_param(pv);
            foreach (acc[k])
                acc[k] = 0;
            for (int i = 0; i <= deg_u; i++)
                for (int j = 0; j <= deg_v; j++)
                begin
                    bu = bernstein(deg_u, i, u);
                    bv = bernstein(deg_v, j, v);
                    dbu = bernstein_slope(deg_u, i, u);
                    dbv = bernstein_slope(deg_v, j, v);
                    w[0] = round_q(bu * bv);
                    w[1] = round_q(dbu * bv);
                    w[2] = round_q(bu * dbv);
                    pt[0] = gx[i * 4 + j];
                    pt[1] = gy[i * 4 + j];
                    pt[2] = gz[i * 4 + j];
                    for (int k = 0; k < 3; k++)
                    begin
                        acc[k] += pt[k] * w[0];
                        acc[3 + k] += pt[k] * w[1];
                        acc[6 + k] += pt[k] * w[2];
                    end
                end
            for (int k = 0; k < bse_pkg::NUM_OUT; k++)
            begin
                r = round_q(acc[k]);
                if (r > SAT_HI)
                    r = SAT_HI;
                if (r < SAT_LO)
                    r = SAT_LO;
                res[k * bse_pkg::OUT_BITS +: bse_pkg::OUT_BITS] = r[bse_pkg::OUT_BITS-1:0];
            end
            surface_q.push_back(res);
        endfunction

        function void check_result(logic [bse_pkg::OUT_TW-1:0] got);
            logic [bse_pkg::OUT_TW-1:0] want;
            if (surface_q.size() == 0)
            begin
                $display("%t unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            want = surface_q.pop_front();
            for (int k = 0; k < bse_pkg::NUM_OUT; k++)
                if (got[k * bse_pkg::OUT_BITS +: bse_pkg::OUT_BITS] !==
                    want[k * bse_pkg::OUT_BITS +: bse_pkg::OUT_BITS])
                begin
                    $display("%t field %0d mismatch: expected %h, got %h", $time, k,
                             want[k * bse_pkg::OUT_BITS +: bse_pkg::OUT_BITS],
                             got[k * bse_pkg::OUT_BITS +: bse_pkg::OUT_BITS]);
                    errors++;
                end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_W-1:0]            s_tdata;
    logic [0:0]                 s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [bse_pkg::OUT_TW-1:0] m_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index;
    logic [1:0]                 cfg_data;

    patch_scoreboard sb;
    int              cyc;
    bit              calm;

    bezier_surface_eval dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        sb = new();
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // receiver: random stall bursts, one long hold-off mid run
    initial
    begin
        bit held;
        held = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && cyc > 4000)
            begin
                m_tready <= 1'b0;
                repeat (500) @(negedge clk);
                held = 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_item(logic act, logic [1:0] row, logic [1:0] col,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [17:0] pu, logic [17:0] pv);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tdata  <= {pv, pu, z, y, x, col, row};
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(act, row, col, x, y, z, pu, pv);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        s_tvalid  <= 1'b0;
        while (sb.surface_q.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_config(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [17:0] rand_param();
        if ($urandom_range(0, 7) == 0)
            return 18'($urandom);
        return 18'($urandom_range(0, ONE));
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++)
            if ($urandom_range(0, 9) < 4)
                send_item(bse_pkg::ACT_LOAD, 2'($urandom), 2'($urandom), $urandom,
                          $urandom, $urandom, 18'($urandom), 18'($urandom));
            else
                send_item(bse_pkg::ACT_EVAL, 2'($urandom), 2'($urandom), $urandom,
                          $urandom, $urandom, rand_param(), rand_param());
    endtask

    initial
    begin
        logic [17:0] edge_params[6];
        logic [1:0]  phase_u[7];
        logic [1:0]  phase_v[7];
        edge_params = '{18'h20000, 18'h1ffff, 18'h0, 18'h10000, 18'h10001, 18'h3ffff};
        phase_u = '{2'd0, 2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1};
        phase_v = '{2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd1};
        cyc = 0;
        calm = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unloaded grid evaluates to zero
        send_item(bse_pkg::ACT_EVAL, 2'd0, 2'd0, '0, '0, '0, 18'h08000, 18'h08000);
        write_reg(bse_pkg::REG_DEGREE_U, 2'd3);
        write_reg(bse_pkg::REG_DEGREE_V, 2'd3);
        write_reg(REG_UNUSED_A, 2'd1);
        write_reg(REG_UNUSED_B, 2'd2);
        send_item(bse_pkg::ACT_LOAD, 2'd0, 2'd0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                  '0, '0);
        send_item(bse_pkg::ACT_LOAD, 2'd3, 2'd3, 32'h80000000, 32'h7fffffff, 32'h00010000,
                  18'h3ffff, 18'h3ffff);
        send_item(bse_pkg::ACT_LOAD, 2'd0, 2'd3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  '0, '0);
        send_item(bse_pkg::ACT_LOAD, 2'd3, 2'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                  '0, '0);
        foreach (edge_params[k])
            send_item(bse_pkg::ACT_EVAL, 2'd3, 2'd3, '1, '1, '1, edge_params[k],
                      edge_params[5 - k]);
        send_item(bse_pkg::ACT_EVAL, 2'd1, 2'd2, '0, '0, '0, 18'h04000, 18'h0c000);

        foreach (phase_u[p])
        begin
            if (p == 6)
                calm = 1;
            write_reg(bse_pkg::REG_DEGREE_U, phase_u[p]);
            write_reg(bse_pkg::REG_DEGREE_V, phase_v[p]);
            random_phase(145);
        end
        s_tvalid <= 1'b0;
        while (sb.surface_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
